FILE: src/ppm_pkg.sv
// Package for the pulse-position infrared frame transmitter.
// Holds the command and register codes, protocol constants, and gap and timing-error tables.
// No dependencies; of the other source files only the transmitter module uses it.
package ppm_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    // Commands carried by an input item.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROTOCOL     = 2'd0;
    localparam logic [1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [1:0] CFG_REPEAT_COUNT = 2'd2;
    localparam logic [1:0] CFG_REPEAT_DELAY = 2'd3;

    localparam logic [8:0]  MAX_LENGTH = 9'd256;
    localparam logic [23:0] BURST_PP4  = 24'd3;
    localparam logic [23:0] BURST_PP16 = 24'd4;
    localparam logic [10:0] BASE_PP4   = 11'd1000;
    localparam logic [10:0] BASE_PP16  = 11'd400;
    localparam logic [10:0] ERR_PP16   = 11'd100;
    localparam logic [6:0]  DELAY_PP4  = 7'd50;
    localparam logic [6:0]  DELAY_PP16 = 7'd125;

    typedef logic [7:0] t_byte;

    function automatic logic [5:0] gap_pp4(input logic [1:0] sym);
        logic [5:0] g;
        case (sym)
            2'd0:    g = 6'd5;
            2'd1:    g = 6'd23;
            2'd2:    g = 6'd11;
            default: g = 6'd17;
        endcase
        return g;
    endfunction

    function automatic logic [10:0] err_pp4(input logic [1:0] sym);
        logic [10:0] e;
        case (sym)
            2'd0:    e = 11'd103;
            2'd1:    e = 11'd414;
            2'd2:    e = 11'd207;
            default: e = 11'd310;
        endcase
        return e;
    endfunction

    function automatic logic [5:0] gap_pp16(input logic [3:0] sym);
        logic [5:0] g;
        case (sym)
            4'd0:    g = 6'd4;
            4'd1:    g = 6'd10;
            4'd2:    g = 6'd6;
            4'd3:    g = 6'd8;
            4'd4:    g = 6'd34;
            4'd5:    g = 6'd28;
            4'd6:    g = 6'd32;
            4'd7:    g = 6'd30;
            4'd8:    g = 6'd18;
            4'd9:    g = 6'd12;
            4'd10:   g = 6'd16;
            4'd11:   g = 6'd14;
            4'd12:   g = 6'd20;
            4'd13:   g = 6'd26;
            4'd14:   g = 6'd22;
            default: g = 6'd24;
        endcase
        return g;
    endfunction

endpackage

FILE: src/ppm_if.sv
// Handshake channel interfaces of the transmitter: command items in, status items out.
// Depends on nothing but the clocking of the module that uses them.
interface ppm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] byte_index;
    logic [7:0] byte_value;

    modport source (output valid, command, byte_index, byte_value, input ready);
    modport sink   (input valid, command, byte_index, byte_value, output ready);
endinterface

interface ppm_out_if;
    logic valid;
    logic ready;
    logic ir_level;
    logic busy_res;
    logic done_res;

    modport source (output valid, ir_level, busy_res, done_res, input ready);
    modport sink   (input valid, ir_level, busy_res, done_res, output ready);
endinterface

FILE: src/ppm_infrared_frame_transmitter.sv
// A result item is presented in the cycle after its input item is accepted.
// One item per cycle when the output is not stalled; a new item enters only when no result is
// held or the held result is taken, so input ready drops only while the output stalls.
// The frame store RAM is read ahead at the byte pointer so a tick never waits on it.
// Reset (synchronous, active low) idles the transmitter and clears the control registers;
// the output data and the frame store keep their contents, the store undefined until written.
module ppm_infrared_frame_transmitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    ppm_in_if.sink     i_in,
    ppm_out_if.source  o_out
);

    // Configuration registers.
    logic        r_protocol;
    logic [8:0]  r_frame_len;
    logic [7:0]  r_repeat_count;
    logic [15:0] r_repeat_delay;

    // Transmitter state.
    logic [23:0] r_countdown, n_countdown;
    logic        r_in_burst, n_in_burst;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_symbol, n_symbol;
    logic [1:0]  r_phase, n_phase;
    logic [8:0]  r_ptr, n_ptr;
    logic [10:0] r_err, n_err;
    logic [7:0]  r_repeats, n_repeats;
    logic        r_active, n_active;
    logic        r_level, n_level;
    logic        n_done;

    // Output register.
    logic r_out_valid;
    logic r_out_level, r_out_busy, r_out_done;

    // Store read-ahead and write forwarding.
    logic                       ram_we;
    ppm_pkg::t_byte             ram_rdata;
    logic                       r_fwd_hit;
    ppm_pkg::t_byte             r_fwd_data;
    ppm_pkg::t_byte             cur_byte;

    logic        accept;
    logic [8:0]  eff_len;
    logic        load;
    logic        ptr_ok;
    ppm_pkg::t_byte src_byte;
    logic [10:0] base;
    logic        over;
    logic [10:0] err_less;
    logic [10:0] err_add;
    logic [5:0]  gap;
    logic [6:0]  delay_mult;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    assign ram_we = accept && (i_in.command == ppm_pkg::CMD_WRITE) &&
                    (32'(i_in.byte_index) < ppm_pkg::FRAME_BYTES);

    ppm_ram #(
        .WIDTH (8),
        .DEPTH (ppm_pkg::FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ppm_pkg::ADDR_W'(i_in.byte_index)),
        .i_wdata (i_in.byte_value),
        .i_raddr (ppm_pkg::ADDR_W'(n_ptr)),
        .o_rdata (ram_rdata)
    );

    // The RAM returns old data when the previous cycle wrote the entry being read.
    assign cur_byte = r_fwd_hit ? r_fwd_data : ram_rdata;

    assign eff_len = (r_frame_len > ppm_pkg::MAX_LENGTH) ? ppm_pkg::MAX_LENGTH : r_frame_len;
    assign ptr_ok  = (r_ptr < eff_len) && (32'(r_ptr) < ppm_pkg::FRAME_BYTES);
    assign load    = r_protocol ? (r_phase[0] == 1'b0) : (r_phase == 2'd0);
    assign src_byte = load ? (ptr_ok ? cur_byte : 8'd0) : r_shift;

    assign base     = r_protocol ? ppm_pkg::BASE_PP16 : ppm_pkg::BASE_PP4;
    assign over     = (r_err >= base);
    assign err_less = over ? (r_err - base) : r_err;
    assign err_add  = r_protocol ? ppm_pkg::ERR_PP16 : ppm_pkg::err_pp4(r_symbol[1:0]);
    assign gap      = r_protocol ? ppm_pkg::gap_pp16(r_symbol) : ppm_pkg::gap_pp4(r_symbol[1:0]);
    assign delay_mult = r_protocol ? ppm_pkg::DELAY_PP16 : ppm_pkg::DELAY_PP4;

    always_comb begin
        n_countdown = r_countdown;
        n_in_burst  = r_in_burst;
        n_shift     = r_shift;
        n_symbol    = r_symbol;
        n_phase     = r_phase;
        n_ptr       = r_ptr;
        n_err       = r_err;
        n_repeats   = r_repeats;
        n_active    = r_active;
        n_level     = r_level;
        n_done      = 1'b0;
        if (accept) begin
            case (i_in.command)
                ppm_pkg::CMD_WRITE: begin
                    n_done = 1'b0;
                end
                ppm_pkg::CMD_START: begin
                    n_ptr       = 9'd0;
                    n_countdown = 24'd0;
                    n_in_burst  = 1'b0;
                    n_phase     = 2'd0;
                    n_err       = 11'd0;
                    n_repeats   = r_repeat_count;
                    n_active    = 1'b1;
                end
                ppm_pkg::CMD_TICK: begin
                    if (!r_active) begin
                        n_done = 1'b0;
                    end else if (r_countdown != 24'd0) begin
                        n_countdown = r_countdown - 24'd1;
                    end else if (!r_in_burst) begin
                        // Burst start: fetch a new byte when the previous one is used up.
                        n_level     = 1'b1;
                        n_countdown = r_protocol ? ppm_pkg::BURST_PP16 : ppm_pkg::BURST_PP4;
                        if (load) begin
                            n_ptr = r_ptr + 9'd1;
                        end
                        if (r_protocol) begin
                            n_symbol = src_byte[3:0];
                            n_shift  = src_byte >> 4;
                        end else begin
                            n_symbol = {2'b00, src_byte[1:0]};
                            n_shift  = src_byte >> 2;
                        end
                        n_phase    = r_phase + 2'd1;
                        n_in_burst = 1'b1;
                    end else begin
                        // Gap start, timing error folded in; at frame end, repeat or finish.
                        n_level     = 1'b0;
                        n_in_burst  = 1'b0;
                        n_countdown = 24'(gap) + 24'(over);
                        n_err       = err_less + err_add;
                        if (r_ptr > eff_len) begin
                            if (r_repeats != 8'd0) begin
                                n_repeats   = r_repeats - 8'd1;
                                n_ptr       = 9'd0;
                                n_phase     = 2'd0;
                                n_err       = 11'd0;
                                n_countdown = 24'(r_repeat_delay) * 24'(delay_mult);
                            end else begin
                                n_active = 1'b0;
                                n_done   = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_done = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol     <= 1'b0;
            r_frame_len    <= 9'd0;
            r_repeat_count <= 8'd0;
            r_repeat_delay <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppm_pkg::CFG_PROTOCOL:     r_protocol     <= i_cfg_data[0];
                ppm_pkg::CFG_FRAME_LENGTH: r_frame_len    <= i_cfg_data[8:0];
                ppm_pkg::CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[7:0];
                ppm_pkg::CFG_REPEAT_DELAY: r_repeat_delay <= i_cfg_data;
                default:                   r_protocol     <= r_protocol;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= 24'd0;
            r_in_burst  <= 1'b0;
            r_shift     <= 8'd0;
            r_symbol    <= 4'd0;
            r_phase     <= 2'd0;
            r_ptr       <= 9'd0;
            r_err       <= 11'd0;
            r_repeats   <= 8'd0;
            r_active    <= 1'b0;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_countdown <= n_countdown;
            r_in_burst  <= n_in_burst;
            r_shift     <= n_shift;
            r_symbol    <= n_symbol;
            r_phase     <= n_phase;
            r_ptr       <= n_ptr;
            r_err       <= n_err;
            r_repeats   <= n_repeats;
            r_active    <= n_active;
            r_level     <= n_level;
            r_fwd_hit   <= ram_we && (9'(i_in.byte_index) == n_ptr);
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_in.byte_value;
        if (accept) begin
            r_out_level <= n_level;
            r_out_busy  <= n_active;
            r_out_done  <= n_done;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.ir_level = r_out_level;
    assign o_out.busy_res = r_out_busy;
    assign o_out.done_res = r_out_done;

    // A burst in progress always drives the emitter.
    a_burst_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_burst |-> r_level)
        else $error("burst active with emitter off");

    // Every accepted item produces a result in the next cycle.
    a_accept_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted item produced no result");

    // The finishing tick reports the transmitter as no longer busy.
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |-> !o_out.busy_res)
        else $error("done reported while busy");

    // A finished transmission leaves the transmitter idle.
    a_done_clears_active : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_done) |=> !r_active)
        else $error("transmitter still active after done");

endmodule

FILE: src/ppm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the contents before a write in the same cycle. No dependencies.
module ppm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
